FILE: design/mftt_pkg.sv
// Package for the motor feedback turn tracker.
// Holds word types, frame constants and configuration register codes.
// No dependencies.
`default_nettype none

package mftt_pkg;

  // Motor table and frame decode
  localparam int MOTOR_COUNT    = 8;
  localparam int MOTOR_IDX_W    = 3;
  localparam int TICKS_PER_TURN = 8192;
  localparam logic [10:0] FB_BASE_ID = 11'h201;

  // Configuration port
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_POSITION_SCALE  = 8'd0,
    CFG_SPEED_SCALE     = 8'd1,
    CFG_CURRENT_SCALE   = 8'd2,
    CFG_HALF_TURN_TICKS = 8'd3
  } cfg_reg_t;

  localparam logic [31:0] POSITION_SCALE_RST = 32'd823550;
  localparam logic [31:0] SPEED_SCALE_RST    = 32'd112441988;
  localparam logic [31:0] CURRENT_SCALE_RST  = 32'd1310720;
  localparam logic [12:0] HALF_TURN_RST      = 13'd4096;

  // Input word: one feedback frame
  typedef struct packed {
    logic [10:0] frame_id;
    logic [7:0]  angle_high;
    logic [7:0]  angle_low;
    logic [7:0]  speed_high;
    logic [7:0]  speed_low;
    logic [7:0]  current_high;
    logic [7:0]  current_low;
    logic [7:0]  temperature_byte;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [MOTOR_IDX_W-1:0] motor_index;
    logic signed [63:0]     position_out;
    logic signed [47:0]     speed_out;
    logic signed [47:0]     current_out;
    logic [7:0]             temperature_out;
  } out_word_t;

  // Request from the pipeline to the turn table
  typedef struct packed {
    logic                   upd;
    logic [MOTOR_IDX_W-1:0] idx;
    logic [15:0]            angle;
  } turn_req_t;

endpackage

`default_nettype wire

FILE: design/mftt_turn_unit.sv
// Per-motor turn table: last angle and turn count, with wrap detection.
// Gives total ticks for the requested motor and updates the entry on upd.
// Depends on mftt_pkg.
`default_nettype none

module mftt_turn_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mftt_pkg::turn_req_t req,
  input  wire logic [12:0]       half_turn,
  output logic [31:0]            tick_sum
);

  logic [15:0] last_angle_r [mftt_pkg::MOTOR_COUNT];
  logic [31:0] revs_r [mftt_pkg::MOTOR_COUNT];

  logic [15:0] delta;
  logic [15:0] half16;
  logic [31:0] count_cur;
  logic [31:0] count_nxt;

  // Wrap detection on the signed 16-bit angle jump
  always_comb begin
    count_cur = revs_r[req.idx];
    delta     = req.angle - last_angle_r[req.idx];
    half16    = {3'b000, half_turn};
    count_nxt = count_cur;
    if ($signed(delta) > $signed(half16)) begin
      count_nxt = count_cur - 32'd1;
    end else if ($signed(delta) < -$signed(half16)) begin
      count_nxt = count_cur + 32'd1;
    end
    tick_sum = {16'd0, req.angle} + 32'(count_nxt * 32'(mftt_pkg::TICKS_PER_TURN));
  end

  // Table write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < mftt_pkg::MOTOR_COUNT; k++) begin
        last_angle_r[k] <= '0;
        revs_r[k]       <= '0;
      end
    end else if (req.upd) begin
      last_angle_r[req.idx] <= req.angle;
      revs_r[req.idx]       <= count_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/motor_feedback_turn_tracker.sv
// Each accepted word passes through the stage-1, stage-2 and result registers to out_data.
// One word per cycle while out_ready does not stall; frames outside the motor id range are dropped.
// Three pipeline stages: capture, turn table update, scale multiplies.
// Reset (synchronous, rst_n low) clears the turn table, the stage valids and
// restores the default scale and half-turn registers.
`default_nettype none

module motor_feedback_turn_tracker (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire mftt_pkg::in_word_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output mftt_pkg::out_word_t                    out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [mftt_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [mftt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Configuration registers
  logic [31:0] pos_gain_r, spd_scale_r, cur_scale_r;
  logic [12:0] half_turn_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_gain_r  <= mftt_pkg::POSITION_SCALE_RST;
      spd_scale_r <= mftt_pkg::SPEED_SCALE_RST;
      cur_scale_r <= mftt_pkg::CURRENT_SCALE_RST;
      half_turn_r <= mftt_pkg::HALF_TURN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mftt_pkg::CFG_POSITION_SCALE:  pos_gain_r  <= cfg_data;
        mftt_pkg::CFG_SPEED_SCALE:     spd_scale_r <= cfg_data;
        mftt_pkg::CFG_CURRENT_SCALE:   cur_scale_r <= cfg_data;
        mftt_pkg::CFG_HALF_TURN_TICKS: half_turn_r <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or the one after it is moving
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic en1, en2, en3;

  assign en3      = !out_valid_r || out_ready;
  assign en2      = !s2_valid_r || en3;
  assign en1      = !s1_valid_r || en2;
  assign in_ready = en1;

  // Stage 1: capture and id decode
  logic [10:0] id_off;
  logic        id_hit;
  logic [mftt_pkg::MOTOR_IDX_W-1:0] s1_idx_r;
  logic [15:0] s1_angle_r, s1_spd_r, s1_cur_r;
  logic [7:0]  s1_temp_r;

  assign id_off = in_data.frame_id - mftt_pkg::FB_BASE_ID;
  assign id_hit = (in_data.frame_id >= mftt_pkg::FB_BASE_ID) &&
                  (id_off < 11'(mftt_pkg::MOTOR_COUNT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en1) begin
      s1_valid_r <= in_valid && id_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_idx_r   <= id_off[mftt_pkg::MOTOR_IDX_W-1:0];
      s1_angle_r <= {in_data.angle_high, in_data.angle_low};
      s1_spd_r   <= {in_data.speed_high, in_data.speed_low};
      s1_cur_r   <= {in_data.current_high, in_data.current_low};
      s1_temp_r  <= in_data.temperature_byte;
    end
  end

  // Stage 2: turn tracking
  mftt_pkg::turn_req_t turn_req;
  logic [31:0] tick_sum;

  assign turn_req.upd   = s1_valid_r && en2;
  assign turn_req.idx   = s1_idx_r;
  assign turn_req.angle = s1_angle_r;

  mftt_turn_unit u_turn (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (turn_req),
    .half_turn (half_turn_r),
    .tick_sum  (tick_sum)
  );

  logic [mftt_pkg::MOTOR_IDX_W-1:0] s2_idx_r;
  logic [31:0] s2_total_r;
  logic [15:0] s2_spd_r, s2_cur_r;
  logic [7:0]  s2_temp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en2) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_idx_r   <= s1_idx_r;
      s2_total_r <= tick_sum;
      s2_spd_r   <= s1_spd_r;
      s2_cur_r   <= s1_cur_r;
      s2_temp_r  <= s1_temp_r;
    end
  end

  // Stage 3: scale multiplies into the result register
  logic signed [63:0] pos_prod;
  logic signed [47:0] spd_prod, cur_prod;
  mftt_pkg::out_word_t out_data_r;

  always_comb begin
    pos_prod = $signed(s2_total_r) * $signed(pos_gain_r);
    spd_prod = $signed(s2_spd_r) * $signed(spd_scale_r);
    cur_prod = $signed(s2_cur_r) * $signed(cur_scale_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en3) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      out_data_r.motor_index     <= s2_idx_r;
      out_data_r.position_out    <= pos_prod;
      out_data_r.speed_out       <= spd_prod;
      out_data_r.current_out     <= cur_prod;
      out_data_r.temperature_out <= s2_temp_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // Input only stalls when every stage is full and the result is held
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && s2_valid_r && out_valid_r && !out_ready))
    else $error("input stalled with a free pipeline stage");

  // A frame outside the id range never enters the pipeline
  a_drop_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !id_hit) |=> !s1_valid_r)
    else $error("out-of-range frame entered the pipeline");

  // The turn table is only written when a stage-1 word moves on
  a_table_upd: assert property (@(posedge clk) disable iff (!rst_n)
    turn_req.upd |=> s2_valid_r)
    else $error("turn table updated without a word advancing");
`endif

endmodule

`default_nettype wire
